// File: hdl/cbb_pkg.sv
package cbb_pkg;

    // defaults for the top-level parameters
    localparam int CAPACITY_DEF    = 4096;
    localparam int MAX_PATTERN_DEF = 8;

    // field widths
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 13;
    localparam int PAT_W  = 64;
    localparam int PLEN_W = 4;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
    localparam logic [OP_W-1:0] OP_RESIZE = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;

    // found_at when there is no match
    localparam logic [POS_W-1:0] FOUND_NONE = '1;

    // control of the search window
    typedef struct packed {
        logic              clear;
        logic              shift;
        logic [BYTE_W-1:0] din;
    } t_win_ctl;

endpackage

// File: hdl/circular_byte_buffer_with_search.sv
// Byte ring buffer with pattern search. Commands arrive on the slave stream
// (op in tuser), one result beat per command leaves on the master stream
// (status in tuser). After reset the block sweeps the whole store to zero,
// one entry a cycle; tready stays low meanwhile. From accept to result:
// push, write, resize, clear, no-op and refused commands pass the command
// register, then execute; pop and read add the registered store read after
// execute. A find whose pattern cannot fit between the start offset and
// the end of the contents answers from execute. Any other find scans the
// bytes from the start offset up to the end of the match or of the
// contents, one byte a cycle from the single store read port into a
// MAX_PATTERN-byte compare window. One command is in flight at a time;
// the next is taken once the block is back in idle and the result
// register is free or being drained.
module circular_byte_buffer_with_search
    import cbb_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] data_byte, [20:8] position, [84:21] pattern,
    // [88:85] pattern_len, [95:89] zero
    input  logic [95:0] i_s_axis_tdata,
    // [2:0] op
    input  logic [2:0]  i_s_axis_tuser,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] data_out, [20:8] fill_level, [33:21] found_at, [39:34] zero
    output logic [39:0] o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]  o_m_axis_tuser
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_RDATA = 3'd3;
    localparam logic [2:0] ST_FIND  = 3'd4;

    // control
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [CW-1:0] r_rd_off, n_rd_off;
    logic [CW-1:0] r_cur_off, n_cur_off;
    logic          r_rd_pend, n_rd_pend;
    logic          r_out_valid, n_out_valid;

    // command payload
    logic [OP_W-1:0]   r_op;
    logic [BYTE_W-1:0] r_data;
    logic [POS_W-1:0]  r_pos;
    logic [PAT_W-1:0]  r_pat;
    logic [PLEN_W-1:0] r_plen;

    // result payload
    logic [BYTE_W-1:0] r_out_data, n_out_data;
    logic [POS_W-1:0]  r_out_fill, n_out_fill;
    logic [POS_W-1:0]  r_out_found, n_out_found;
    logic [STAT_W-1:0] r_out_status, n_out_status;

    // store port
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    t_win_ctl win_ctl;
    logic     win_hit;

    logic s_accept;
    logic [WW-1:0] cnt_w, pos_w, cap_w, plen_w, rd_off_w, cur_off_w;
    logic find_bad, find_short;
    logic          load;
    logic [BYTE_W-1:0] ld_data;
    logic [POS_W-1:0]  ld_found;
    logic [STAT_W-1:0] ld_status;

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign cnt_w     = WW'(r_cnt);
    assign pos_w     = WW'(r_pos);
    assign cap_w     = WW'(CAPACITY);
    assign plen_w    = WW'(r_plen);
    assign rd_off_w  = WW'(r_rd_off);
    assign cur_off_w = WW'(r_cur_off);

    // find refused on a bad length; empty result when no match can fit
    assign find_bad   = (r_plen == '0) || (r_plen > PLEN_W'(MAX_PATTERN));
    assign find_short = (pos_w + plen_w) > cnt_w;

    assign win_ctl.clear = (r_state == ST_EXEC) && (r_op == OP_FIND);
    assign win_ctl.shift = (r_state == ST_FIND) && r_rd_pend;
    assign win_ctl.din   = ram_rdata;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_clr_addr  = r_clr_addr;
        n_rd_off    = r_rd_off;
        n_cur_off   = r_cur_off;
        n_rd_pend   = 1'b0;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_fill   = r_out_fill;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;

        ram_we    = 1'b0;
        ram_waddr = r_head + AW'(r_pos);
        ram_wdata = r_data;
        ram_re    = 1'b0;
        ram_raddr = r_head + AW'(r_pos);

        load      = 1'b0;
        ld_data   = '0;
        ld_found  = FOUND_NONE;
        ld_status = STAT_OK;

        case (r_state)
            ST_CLR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                load    = 1'b1;
                case (r_op)
                    OP_PUSH: begin
                        if (cnt_w >= cap_w) begin
                            ld_status = STAT_OVERFLOW;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_head + AW'(r_cnt);
                            n_cnt     = r_cnt + CW'(1);
                        end
                    end
                    OP_POP: begin
                        if (r_cnt == '0) begin
                            ld_status = STAT_RANGE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = r_head;
                            n_head    = r_head + AW'(1);
                            n_cnt     = r_cnt - CW'(1);
                            load      = 1'b0;
                            n_state   = ST_RDATA;
                        end
                    end
                    OP_READ: begin
                        if (pos_w >= cnt_w) begin
                            ld_status = STAT_RANGE;
                        end else begin
                            ram_re  = 1'b1;
                            load    = 1'b0;
                            n_state = ST_RDATA;
                        end
                    end
                    OP_WRITE: begin
                        if (pos_w >= cnt_w) begin
                            ld_status = STAT_RANGE;
                        end else begin
                            ram_we = 1'b1;
                        end
                    end
                    OP_RESIZE: begin
                        if (pos_w > cap_w) begin
                            ld_status = STAT_OVERFLOW;
                        end else begin
                            // shrinking drops bytes at the front
                            if (pos_w <= cnt_w) begin
                                n_head = r_head + AW'(cnt_w - pos_w);
                            end
                            n_cnt = CW'(pos_w);
                        end
                    end
                    OP_CLEAR: begin
                        n_head = '0;
                        n_cnt  = '0;
                    end
                    OP_FIND: begin
                        if (find_bad) begin
                            ld_status = STAT_RANGE;
                        end else if (!find_short) begin
                            n_rd_off = CW'(pos_w);
                            load     = 1'b0;
                            n_state  = ST_FIND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_RDATA: begin
                load    = 1'b1;
                ld_data = ram_rdata;
                n_state = ST_IDLE;
            end
            ST_FIND: begin
                // one read issued per cycle, data compared the next
                if (rd_off_w < cnt_w) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_head + AW'(r_rd_off);
                    n_rd_off  = r_rd_off + CW'(1);
                    n_cur_off = r_rd_off;
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    if (win_hit) begin
                        load     = 1'b1;
                        ld_found = POS_W'(cur_off_w + WW'(1) - plen_w);
                        n_state  = ST_IDLE;
                    end else if ((cur_off_w + WW'(1)) == cnt_w) begin
                        load    = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid  = 1'b1;
            n_out_data   = ld_data;
            n_out_fill   = POS_W'(n_cnt);
            n_out_found  = ld_found;
            n_out_status = ld_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_head      <= '0;
            r_cnt       <= '0;
            r_clr_addr  <= '0;
            r_rd_off    <= '0;
            r_cur_off   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_clr_addr  <= n_clr_addr;
            r_rd_off    <= n_rd_off;
            r_cur_off   <= n_cur_off;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op   <= i_s_axis_tuser;
            r_data <= i_s_axis_tdata[7:0];
            r_pos  <= i_s_axis_tdata[20:8];
            r_pat  <= i_s_axis_tdata[84:21];
            r_plen <= i_s_axis_tdata[88:85];
        end
        r_out_data   <= n_out_data;
        r_out_fill   <= n_out_fill;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
    end

    cbb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cbb_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (win_ctl),
        .i_pattern (r_pat[MAX_PATTERN*8-1:0]),
        .i_plen    (r_plen),
        .o_hit     (win_hit)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_found, r_out_fill, r_out_data};
    assign o_m_axis_tuser  = r_out_status;

endmodule

// File: hdl/cbb_ram.sv
module cbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/cbb_match.sv
module cbb_match
    import cbb_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_win_ctl                    i_ctl,
    input  logic [MAX_PATTERN*8-1:0]    i_pattern,
    input  logic [PLEN_W-1:0]           i_plen,
    output logic                        o_hit
);

    // window holds the last plen bytes, oldest in slot 0
    logic [BYTE_W-1:0] r_win [MAX_PATTERN];
    logic [BYTE_W-1:0] n_win [MAX_PATTERN];
    logic [PLEN_W-1:0] r_loaded;
    logic [PLEN_W-1:0] n_loaded;
    logic [MAX_PATTERN-1:0] w_eq;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_win
            localparam logic [PLEN_W-1:0] SLOT_NEXT = PLEN_W'(gi + 1);
            always_comb begin
                n_win[gi] = r_win[gi];
                if (i_ctl.shift) begin
                    if (SLOT_NEXT == i_plen) begin
                        n_win[gi] = i_ctl.din;
                    end else if (SLOT_NEXT < i_plen) begin
                        if (gi < MAX_PATTERN - 1) begin
                            n_win[gi] = r_win[(gi + 1) % MAX_PATTERN];
                        end
                    end
                end
            end
            assign w_eq[gi] = (PLEN_W'(gi) >= i_plen) ||
                              (n_win[gi] == i_pattern[gi*8 +: 8]);
            always_ff @(posedge i_clk) begin
                r_win[gi] <= n_win[gi];
            end
        end
    endgenerate

    always_comb begin
        n_loaded = r_loaded;
        if (i_ctl.clear) begin
            n_loaded = '0;
        end else if (i_ctl.shift && (r_loaded < PLEN_W'(MAX_PATTERN))) begin
            n_loaded = r_loaded + PLEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
        end else begin
            r_loaded <= n_loaded;
        end
    end

    // hit on the byte now shifting in
    assign o_hit = i_ctl.shift && (n_loaded >= i_plen) && (&w_eq);

endmodule

// File: verif/cbb_checker.sv
`timescale 1ns / 100ps

// Watches both streams. Every command beat runs through a software copy of the
// ring; every result beat is compared against the oldest predicted reply.
module cbb_checker
    import cbb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_tvalid,
    input  logic        i_cmd_tready,
    input  logic [95:0] i_cmd_tdata,
    input  logic [2:0]  i_cmd_tuser,
    input  logic        i_res_tvalid,
    input  logic        i_res_tready,
    input  logic [39:0] i_res_tdata,
    input  logic [1:0]  i_res_tuser,
    input  logic        i_end_check,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int IDX_W = $clog2(CAPACITY_DEF);

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic [POS_W-1:0]  fill_level;
        logic [POS_W-1:0]  found_at;
        logic [STAT_W-1:0] status;
    } t_ring_reply;

    logic [BYTE_W-1:0] ring_mem [CAPACITY_DEF];
    logic [IDX_W-1:0]  ring_head;
    logic [POS_W-1:0]  ring_fill;
    t_ring_reply       pending_replies [$];
    int                fails;

    initial begin
        for (int i = 0; i < CAPACITY_DEF; i++) ring_mem[i] = '0;
        ring_head = '0;
        ring_fill = '0;
        fails     = 0;
    end

    function automatic logic [IDX_W-1:0] ring_slot(input int off);
        logic [IDX_W-1:0] s;
        s = ring_head + off[IDX_W-1:0];
        return s;
    endfunction

    function automatic bit pattern_at(input int start, input logic [PAT_W-1:0] pat,
                                      input int len);
        for (int i = 0; i < len; i++)
            if (ring_mem[ring_slot(start + i)] != pat[8*i +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fails++;
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // one command beat -> one predicted reply
    task automatic ring_apply(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                              input logic [POS_W-1:0] pos, input logic [PAT_W-1:0] pat,
                              input logic [PLEN_W-1:0] plen);
        t_ring_reply r;
        r.data_out = '0;
        r.found_at = FOUND_NONE;
        r.status   = STAT_OK;
        case (op)
            OP_PUSH: begin
                if (ring_fill >= CAPACITY_DEF) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    ring_mem[ring_slot(int'(ring_fill))] = din;
                    ring_fill++;
                end
            end
            OP_POP: begin
                if (ring_fill == 0) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.data_out = ring_mem[ring_head];
                    ring_head++;
                    ring_fill--;
                end
            end
            OP_READ: begin
                if (pos >= ring_fill) r.status = STAT_RANGE;
                else r.data_out = ring_mem[ring_slot(int'(pos))];
            end
            OP_WRITE: begin
                if (pos >= ring_fill) r.status = STAT_RANGE;
                else ring_mem[ring_slot(int'(pos))] = din;
            end
            OP_RESIZE: begin
                if (pos > CAPACITY_DEF) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    // shrinking drops bytes at the front
                    if (pos <= ring_fill) ring_head = ring_slot(int'(ring_fill - pos));
                    ring_fill = pos;
                end
            end
            OP_CLEAR: begin
                ring_head = '0;
                ring_fill = '0;
            end
            OP_FIND: begin
                if (plen == 0 || plen > MAX_PATTERN_DEF) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (int p = int'(pos); p + int'(plen) <= int'(ring_fill); p++) begin
                        if (pattern_at(p, pat, int'(plen))) begin
                            r.found_at = p[POS_W-1:0];
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.fill_level = ring_fill;
        pending_replies.push_back(r);
    endtask

    task automatic check_reply(input logic [39:0] tdata, input logic [STAT_W-1:0] stat);
        t_ring_reply want;
        if (pending_replies.size() == 0) begin
            report_mismatch("result beat with no command pending", int'(tdata), 0);
        end else begin
            want = pending_replies.pop_front();
            if (tdata[7:0] !== want.data_out)
                report_mismatch("data_out", int'(tdata[7:0]), int'(want.data_out));
            if (tdata[20:8] !== want.fill_level)
                report_mismatch("fill_level", int'(tdata[20:8]), int'(want.fill_level));
            if (tdata[33:21] !== want.found_at)
                report_mismatch("found_at", int'(tdata[33:21]), int'(want.found_at));
            if (stat !== want.status)
                report_mismatch("status", int'(stat), int'(want.status));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_cmd_tvalid && i_cmd_tready)
            ring_apply(i_cmd_tuser, i_cmd_tdata[7:0], i_cmd_tdata[20:8],
                       i_cmd_tdata[84:21], i_cmd_tdata[88:85]);
        if (i_rst_n && i_res_tvalid && i_res_tready)
            check_reply(i_res_tdata, i_res_tuser);
        if (i_end_check && pending_replies.size() != 0)
            report_mismatch("replies never delivered", 0, pending_replies.size());
        o_fail_count <= fails;
        o_pending    <= pending_replies.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the ring buffer. Prediction and comparison live in
// cbb_checker, which sits beside the block and watches both streams.
module tb_top;
    import cbb_pkg::*;

    // op code seven has no name in the package: it is a no-op
    localparam logic [OP_W-1:0] OP_NOP = 3'd7;

    localparam int RANDOM_CMDS = 700;
    localparam int LONG_HOLD   = 400;   // cycles the result side stays closed once
    localparam int HOLD_AFTER  = 60;    // result beats seen before that hold

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        cmd_tvalid = 1'b0;
    logic        cmd_tready;
    logic [95:0] cmd_tdata  = '0;       // [7:0] byte, [20:8] position, [84:21] pattern,
                                        // [88:85] pattern_len, [95:89] zero
    logic [2:0]  cmd_tuser  = '0;       // [2:0] op
    logic        res_tvalid;
    logic        res_tready = 1'b0;
    logic [39:0] res_tdata;             // [7:0] data_out, [20:8] fill_level,
                                        // [33:21] found_at, [39:34] zero
    logic [1:0]  res_tuser;             // [1:0] status
    logic        end_check  = 1'b0;
    int          fail_count;
    int          pending;

    always #2 i_clk = ~i_clk;

    circular_byte_buffer_with_search u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (cmd_tvalid),
        .o_s_axis_tready (cmd_tready),
        .i_s_axis_tdata  (cmd_tdata),
        .i_s_axis_tuser  (cmd_tuser),
        .o_m_axis_tvalid (res_tvalid),
        .i_m_axis_tready (res_tready),
        .o_m_axis_tdata  (res_tdata),
        .o_m_axis_tuser  (res_tuser)
    );

    cbb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_tvalid (cmd_tvalid),
        .i_cmd_tready (cmd_tready),
        .i_cmd_tdata  (cmd_tdata),
        .i_cmd_tuser  (cmd_tuser),
        .i_res_tvalid (res_tvalid),
        .i_res_tready (res_tready),
        .i_res_tdata  (res_tdata),
        .i_res_tuser  (res_tuser),
        .i_end_check  (end_check),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one command beat and hold it until the block takes it. Called
    // right after a rising edge; returns at the edge that accepted the beat.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                            input logic [POS_W-1:0] pos, input logic [PAT_W-1:0] pat,
                            input logic [PLEN_W-1:0] plen);
        cmd_tvalid <= 1'b1;
        cmd_tdata  <= {7'd0, plen, pat, pos, din};
        cmd_tuser  <= op;
        do @(posedge i_clk); while (!cmd_tready);
    endtask

    task automatic idle_cycles(input int n);
        cmd_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // sender pause: nothing new until every predicted reply has come back
    task automatic drain_replies();
        cmd_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly a tiny alphabet so that searches hit often; now and then any byte.
    function automatic logic [BYTE_W-1:0] draw_byte();
        if ($urandom_range(0, 9) < 6) return BYTE_W'($urandom_range(0, 3));
        return BYTE_W'($urandom);
    endfunction

    task automatic pick_cmd(output logic [OP_W-1:0] op, output logic [BYTE_W-1:0] din,
                            output logic [POS_W-1:0] pos, output logic [PAT_W-1:0] pat,
                            output logic [PLEN_W-1:0] plen);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 24)      op = OP_PUSH;
        else if (roll < 40) op = OP_POP;
        else if (roll < 52) op = OP_READ;
        else if (roll < 62) op = OP_WRITE;
        else if (roll < 70) op = OP_RESIZE;
        else if (roll < 72) op = OP_CLEAR;
        else if (roll < 95) op = OP_FIND;
        else                op = OP_NOP;
        din = draw_byte();

        // offsets stay near the small contents most of the time
        roll = $urandom_range(0, 99);
        if (op == OP_RESIZE) begin
            // full-size growth is rare: searches over a full ring are slow
            if (roll < 80)      pos = POS_W'($urandom_range(0, 40));
            else if (roll < 88) pos = POS_W'($urandom_range(41, 300));
            else if (roll < 93) pos = POS_W'(CAPACITY_DEF);
            else if (roll < 96) pos = POS_W'($urandom_range(CAPACITY_DEF - 3,
                                                             CAPACITY_DEF - 1));
            else                pos = POS_W'($urandom_range(CAPACITY_DEF + 1, 8191));
        end else begin
            if (roll < 85)      pos = POS_W'($urandom_range(0, 40));
            else if (roll < 95) pos = POS_W'($urandom_range(0, 300));
            else                pos = POS_W'($urandom_range(0, 8191));
        end

        if ($urandom_range(0, 3) != 0) begin
            for (int i = 0; i < 8; i++) pat[8*i +: 8] = BYTE_W'($urandom_range(0, 3));
        end else begin
            pat = {$urandom, $urandom};
        end

        // lengths of zero and above eight are refused
        roll = $urandom_range(0, 19);
        if (roll == 0)      plen = '0;
        else if (roll == 1) plen = PLEN_W'($urandom_range(9, 15));
        else if (roll < 14) plen = PLEN_W'($urandom_range(1, 3));
        else                plen = PLEN_W'($urandom_range(1, 8));
    endtask

    // Result side: stretches that are always ready, half ready or mostly
    // stalled, plus one long hold-off so the block backs up and drops tready.
    initial begin : result_side
        int  stretch;
        int  mode;
        int  beats;
        bit  held;
        stretch = 0;
        mode    = 0;
        beats   = 0;
        held    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_tvalid && res_tready) beats++;
            if (!held && beats >= HOLD_AFTER) begin
                held = 1'b1;
                res_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (stretch == 0) begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(10, 80);
                end
                stretch--;
                case (mode)
                    0, 1:    res_tready <= 1'b1;
                    2:       res_tready <= ($urandom_range(0, 1) == 1);
                    default: res_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int                burst_left;
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] din;
        logic [POS_W-1:0]  pos;
        logic [PAT_W-1:0]  pat;
        logic [PLEN_W-1:0] plen;

        burst_left = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // on an empty ring: a find with an empty result, then refusals
        send_cmd(OP_FIND,   8'h00, 13'd0, 64'h0, 4'd1);
        send_cmd(OP_POP,    8'h00, 13'd0, 64'h0, 4'd1);
        send_cmd(OP_READ,   8'h00, 13'd0, 64'h0, 4'd1);
        send_cmd(OP_WRITE,  8'h33, 13'd0, 64'h0, 4'd1);
        // byte extremes, then overwrite the back byte
        send_cmd(OP_PUSH,   8'h00, 13'd0, 64'h0, 4'd1);
        send_cmd(OP_PUSH,   8'hFF, 13'd0, 64'h0, 4'd1);
        send_cmd(OP_PUSH,   8'hA5, 13'd0, 64'h0, 4'd1);
        send_cmd(OP_READ,   8'h00, 13'd1, 64'h0, 4'd1);
        send_cmd(OP_WRITE,  8'h5A, 13'd2, 64'h0, 4'd1);
        send_cmd(OP_READ,   8'h00, 13'h1FFF, 64'h0, 4'd1);
        // two-byte match at offset one; refused pattern lengths
        send_cmd(OP_FIND,   8'h00, 13'd0, 64'h5AFF, 4'd2);
        send_cmd(OP_FIND,   8'h00, 13'd0, 64'h5AFF, 4'd0);
        send_cmd(OP_FIND,   8'h00, 13'd0, 64'h5AFF, 4'd15);
        send_cmd(OP_FIND,   8'h00, 13'd0, 64'h5AFF, 4'd9);
        send_cmd(OP_POP,    8'h00, 13'd0, 64'h0, 4'd1);
        // growth past capacity refused, growth to capacity exposes old store
        send_cmd(OP_RESIZE, 8'h00, 13'(CAPACITY_DEF + 1), 64'h0, 4'd1);
        send_cmd(OP_RESIZE, 8'h00, 13'(CAPACITY_DEF), 64'h0, 4'd1);
        send_cmd(OP_PUSH,   8'h77, 13'd0, 64'h0, 4'd1);
        // full-length search over the full ring with no hit
        send_cmd(OP_FIND,   8'h00, 13'd0, {64{1'b1}}, 4'd8);
        // shrink drops the front, keeps the back byte
        send_cmd(OP_RESIZE, 8'h00, 13'd1, 64'h0, 4'd1);
        send_cmd(OP_NOP,    8'hFF, 13'h1FFF, {64{1'b1}}, 4'hF);
        send_cmd(OP_FIND,   8'h00, 13'd4095, 64'h0, 4'd1);
        // clear keeps the store; growing shows the old bytes again
        send_cmd(OP_CLEAR,  8'h00, 13'd0, 64'h0, 4'd1);
        send_cmd(OP_RESIZE, 8'h00, 13'd3, 64'h0, 4'd1);
        send_cmd(OP_READ,   8'h00, 13'd2, 64'h0, 4'd1);
        drain_replies();

        // ---- random part ----
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            if (k % 200 == 199) begin
                drain_replies();
            end else if (burst_left == 0) begin
                idle_cycles($urandom_range(1, 8));
                burst_left = $urandom_range(1, 30);
            end
            pick_cmd(op, din, pos, pat, plen);
            send_cmd(op, din, pos, pat, plen);
            if (burst_left > 0) burst_left--;
        end
        drain_replies();

        // catch stray result beats, then flag leftovers
        repeat (30) @(posedge i_clk);
        end_check <= 1'b1;
        @(posedge i_clk);
        end_check <= 1'b0;
        repeat (2) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hard stop: far beyond the slowest legal run, including the reset sweep
    // and a full-ring scan for every command
    initial begin : watchdog
        #(100_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
hdl/cbb_pkg.sv
hdl/cbb_ram.sv
hdl/cbb_match.sv
hdl/circular_byte_buffer_with_search.sv
verif/cbb_checker.sv
verif/tb_top.sv
